// ===== sv/gfba_pkg.sv =====
// ---------------------------------------------------------------------------
// gfba_pkg: shared types for the grouped free-block allocator
// Command, status, phase and back-end state codes used by front and back.
// ---------------------------------------------------------------------------
package gfba_pkg;

	// width of every block number and data field on the ports
	localparam int FIELD_W = 24;

	// input action codes
	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_FREE   = 2'd1;
	localparam logic [1:0] ACT_REFILL = 2'd2;

	// classified command held in the queue
	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_FREE,
		OP_REFILL
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [FIELD_W-1:0] blk;
		logic [FIELD_W-1:0] word;
	} cmd_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_GRANTED = 3'd0,
		ST_NOSPACE = 3'd1,
		ST_SPILL   = 3'd2,
		ST_FREED   = 3'd3,
		ST_REFILL  = 3'd4
	} status_t;

	typedef struct packed {
		status_t            status;
		logic [FIELD_W-1:0] blk;
		logic [FIELD_W-1:0] word;
		logic               need;
		logic               last;
	} result_t;

	// refill progress
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_COUNT,
		PH_ENTRIES
	} phase_t;

	// back-end sequencer
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ALLOC_RD,
		BK_SPILL_RD,
		BK_SPILL_EMIT
	} bk_state_t;

endpackage

// ===== sv/grouped_free_block_allocator.sv =====
// ---------------------------------------------------------------------------
// grouped_free_block_allocator: chained free-list block allocator
// Front end queues decoded requests; back end works the on-chip stack.
// ---------------------------------------------------------------------------
// Free and refill words pass the command queue and output register and may
//   follow back to back while m_tready takes results; allocate also passes
//   the registered stack RAM read and holds the back end until it is done. A
//   spill run emits a header word, then each stack entry through the single RAM read port.
// Reset: clears the queue, stack count, refill state and output valid; the
//   stack RAM is not cleared and needs no clearing pass.
module grouped_free_block_allocator #(
	parameter int GROUP_SIZE        = 32,
	parameter int BLOCK_NUMBER_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // block_number[23:0], loaded_word[47:24]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // granted_block[23:0], spill_word[47:24]
	output logic [3:0]  m_tuser,   // status[2:0], refill_needed[3]
	output logic        m_tlast
);

	logic              cmd_valid;
	gfba_pkg::cmd_t    cmd;
	logic              cmd_pop;
	gfba_pkg::result_t res;

	gfba_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (s_tuser),
		.in_blk    (s_tdata[23:0]),
		.in_word   (s_tdata[47:24]),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	gfba_back #(
		.GROUP_SIZE        (GROUP_SIZE),
		.BLOCK_NUMBER_BITS (BLOCK_NUMBER_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (m_tvalid),
		.res       (res),
		.res_ready (m_tready)
	);

	// result word packing
	assign m_tdata = {res.word, res.blk};
	assign m_tuser = {res.need, res.status};
	assign m_tlast = res.last;

endmodule

// ===== sv/gfba_ram.sv =====
// ---------------------------------------------------------------------------
// gfba_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data held when idle.
// ---------------------------------------------------------------------------
module gfba_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/gfba_front.sv =====
// ---------------------------------------------------------------------------
// gfba_front: input classification and command queue
// Accepts words, decodes the action, drops unknown codes and queues the
// rest in a two-entry FIFO for the back end.
// ---------------------------------------------------------------------------
module gfba_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    in_action,
	input  logic [gfba_pkg::FIELD_W-1:0]  in_blk,
	input  logic [gfba_pkg::FIELD_W-1:0]  in_word,
	output logic                          cmd_valid,
	output gfba_pkg::cmd_t                cmd,
	input  logic                          cmd_pop
);

	localparam int QDepth = 2;
	localparam int PtrW   = $clog2(QDepth);

	gfba_pkg::cmd_t     q_mem_q [QDepth];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [PtrW:0]      fill_q;
	logic               known;
	gfba_pkg::op_t      op;
	logic               push;

	// decode action
	always_comb begin
		known = 1'b1;
		op    = gfba_pkg::OP_ALLOC;
		unique case (in_action)
			gfba_pkg::ACT_ALLOC:  op = gfba_pkg::OP_ALLOC;
			gfba_pkg::ACT_FREE:   op = gfba_pkg::OP_FREE;
			gfba_pkg::ACT_REFILL: op = gfba_pkg::OP_REFILL;
			default:              known = 1'b0;
		endcase
	end

	assign in_ready  = (fill_q != (PtrW+1)'(QDepth));
	assign push      = in_valid && in_ready && known;
	assign cmd_valid = (fill_q != '0);
	assign cmd       = q_mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= '{op: op, blk: in_blk, word: in_word};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && cmd_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/gfba_back.sv =====
// ---------------------------------------------------------------------------
// gfba_back: stack execution engine
// Pops queued commands, runs push, pop, spill and refill on the stack RAM
// and holds one result word in an output register.
// ---------------------------------------------------------------------------
module gfba_back #(
	parameter int GROUP_SIZE        = 32,
	parameter int BLOCK_NUMBER_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  gfba_pkg::cmd_t    cmd,
	output logic              cmd_pop,
	output logic              res_valid,
	output gfba_pkg::result_t res,
	input  logic              res_ready
);

	localparam int FW     = gfba_pkg::FIELD_W;
	localparam int EntryW = (BLOCK_NUMBER_BITS < FW) ? BLOCK_NUMBER_BITS : FW;
	localparam int CntW   = $clog2(GROUP_SIZE + 1);
	localparam int AddrW  = $clog2(GROUP_SIZE);

	gfba_pkg::bk_state_t state_q, state_d;
	gfba_pkg::phase_t    phase_q, phase_d;
	logic [CntW-1:0]     count_q, count_d;
	logic [CntW-1:0]     rf_idx_q, rf_idx_d;
	logic [CntW-1:0]     rf_total_q, rf_total_d;
	logic [CntW-1:0]     rf_idx_nx;
	logic [CntW-1:0]     rf_cnt;
	logic [AddrW-1:0]    sp_idx_q, sp_idx_d;
	logic [EntryW-1:0]   blk_q, blk_d;

	logic                out_valid_q;
	gfba_pkg::result_t   out_q;
	gfba_pkg::result_t   res_d;
	logic                out_load;
	logic                out_free;

	logic                ram_we;
	logic [AddrW-1:0]    ram_waddr;
	logic [EntryW-1:0]   ram_wdata;
	logic                ram_re;
	logic [AddrW-1:0]    ram_raddr;
	logic [EntryW-1:0]   ram_rdata;

	gfba_ram #(
		.WIDTH (EntryW),
		.DEPTH (GROUP_SIZE)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free  = !out_valid_q || res_ready;
	assign res_valid = out_valid_q;
	assign res       = out_q;
	assign rf_idx_nx = rf_idx_q + 1'b1;
	assign rf_cnt    = (cmd.word > FW'(GROUP_SIZE)) ? CntW'(GROUP_SIZE)
	                                                : cmd.word[CntW-1:0];

	// sequencer: next state, stack control and result word
	always_comb begin
		state_d    = state_q;
		phase_d    = phase_q;
		count_d    = count_q;
		rf_idx_d   = rf_idx_q;
		rf_total_d = rf_total_q;
		sp_idx_d   = sp_idx_q;
		blk_d      = blk_q;
		cmd_pop    = 1'b0;
		out_load   = 1'b0;
		res_d      = '{status: gfba_pkg::ST_NOSPACE, blk: '0, word: '0,
		               need: 1'b0, last: 1'b0};
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = '0;
		ram_re     = 1'b0;
		ram_raddr  = '0;

		unique case (state_q)
			gfba_pkg::BK_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						gfba_pkg::OP_ALLOC: begin
							if (phase_q != gfba_pkg::PH_IDLE || count_q == '0) begin
								out_load = 1'b1;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = AddrW'(count_q - 1'b1);
								count_d   = count_q - 1'b1;
								state_d   = gfba_pkg::BK_ALLOC_RD;
							end
						end
						gfba_pkg::OP_FREE: begin
							if (phase_q != gfba_pkg::PH_IDLE) begin
								out_load = 1'b1;
							end else if (count_q >= CntW'(GROUP_SIZE)) begin
								// full: header word, then every entry
								blk_d        = cmd.blk[EntryW-1:0];
								out_load     = 1'b1;
								res_d.status = gfba_pkg::ST_SPILL;
								res_d.blk    = FW'(cmd.blk[EntryW-1:0]);
								res_d.word   = FW'(count_q);
								sp_idx_d     = '0;
								state_d      = gfba_pkg::BK_SPILL_RD;
							end else begin
								ram_we       = 1'b1;
								ram_waddr    = count_q[AddrW-1:0];
								ram_wdata    = cmd.blk[EntryW-1:0];
								count_d      = count_q + 1'b1;
								out_load     = 1'b1;
								res_d.status = gfba_pkg::ST_FREED;
							end
						end
						gfba_pkg::OP_REFILL: begin
							unique case (phase_q)
								gfba_pkg::PH_COUNT: begin
									rf_total_d   = rf_cnt;
									rf_idx_d     = '0;
									out_load     = 1'b1;
									res_d.status = gfba_pkg::ST_REFILL;
									if (rf_cnt == '0) begin
										phase_d    = gfba_pkg::PH_IDLE;
										count_d    = '0;
										res_d.last = 1'b1;
									end else begin
										phase_d = gfba_pkg::PH_ENTRIES;
									end
								end
								gfba_pkg::PH_ENTRIES: begin
									ram_we       = 1'b1;
									ram_waddr    = rf_idx_q[AddrW-1:0];
									ram_wdata    = cmd.word[EntryW-1:0];
									rf_idx_d     = rf_idx_nx;
									out_load     = 1'b1;
									res_d.status = gfba_pkg::ST_REFILL;
									if (rf_idx_nx >= rf_total_q) begin
										count_d    = rf_total_q;
										phase_d    = gfba_pkg::PH_IDLE;
										res_d.last = 1'b1;
									end
								end
								default: begin
									// refill word with nothing pending: dropped
								end
							endcase
						end
						default: begin
						end
					endcase
				end
			end
			gfba_pkg::BK_ALLOC_RD: begin
				// output slot stays free since the command was popped
				out_load = 1'b1;
				state_d  = gfba_pkg::BK_IDLE;
				if (ram_rdata == '0) begin
					count_d = '0;
				end else begin
					res_d.status = gfba_pkg::ST_GRANTED;
					res_d.blk    = FW'(ram_rdata);
					if (count_q == '0) begin
						// popped block holds the next group
						res_d.need = 1'b1;
						phase_d    = gfba_pkg::PH_COUNT;
						rf_idx_d   = '0;
						rf_total_d = '0;
					end
				end
			end
			gfba_pkg::BK_SPILL_RD: begin
				ram_re    = 1'b1;
				ram_raddr = sp_idx_q;
				state_d   = gfba_pkg::BK_SPILL_EMIT;
			end
			gfba_pkg::BK_SPILL_EMIT: begin
				if (out_free) begin
					out_load     = 1'b1;
					res_d.status = gfba_pkg::ST_SPILL;
					res_d.blk    = FW'(blk_q);
					res_d.word   = FW'(ram_rdata);
					if (sp_idx_q == AddrW'(GROUP_SIZE - 1)) begin
						// run done: stack restarts with the freed block
						res_d.last = 1'b1;
						ram_we     = 1'b1;
						ram_waddr  = '0;
						ram_wdata  = blk_q;
						count_d    = CntW'(1);
						state_d    = gfba_pkg::BK_IDLE;
					end else begin
						sp_idx_d = sp_idx_q + 1'b1;
						state_d  = gfba_pkg::BK_SPILL_RD;
					end
				end
			end
			default: begin
				state_d = gfba_pkg::BK_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gfba_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= gfba_pkg::PH_IDLE;
			count_q     <= '0;
			rf_idx_q    <= '0;
			rf_total_q  <= '0;
			sp_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			count_q    <= count_d;
			rf_idx_q   <= rf_idx_d;
			rf_total_q <= rf_total_d;
			sp_idx_q   <= sp_idx_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		blk_q <= blk_d;
		if (out_load) begin
			out_q <= res_d;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(GROUP_SIZE))
		else $error("stack count above group size");

	a_refill_empty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != gfba_pkg::PH_IDLE |-> count_q == '0)
		else $error("stack not empty during refill");

	a_spill_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gfba_pkg::BK_SPILL_RD || state_q == gfba_pkg::BK_SPILL_EMIT)
		|-> count_q == CntW'(GROUP_SIZE))
		else $error("spill run on a stack that is not full");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_valid_q |-> res_ready)
		else $error("result word overwritten before it was taken");

	a_alloc_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gfba_pkg::BK_ALLOC_RD |=> out_valid_q)
		else $error("allocate produced no result");
`endif

endmodule
